// ===== rtl/swmm_pkg.sv =====
package swmm_pkg;

    localparam int MAX_WINDOW  = 1024;
    localparam int SAMPLE_BITS = 32;
    localparam int AGE_W       = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W       = 11;
    localparam int SEEN_W      = 11;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 2;

    localparam logic [SEEN_W-1:0] SEEN_LIMIT = {SEEN_W{1'b1}};
    localparam logic [CFG_W-1:0]  WIN_RESET  = CFG_W'(1);

    localparam logic [ADDR_W-1:0] WINDOW_SIZE_ADDR = ADDR_W'(0);

    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] value;
        logic [AGE_W-1:0]              age;
    } entry_t;

    typedef struct packed {
        logic                          step;
        logic                          shift;
        logic                          clear;
        logic                          keep_max;
        logic signed [SAMPLE_BITS-1:0] sample;
    } ctrl_t;

endpackage

// ===== rtl/sliding_window_min_max.sv =====
// Latency: a result appears on the m_ channel in the cycle after its sample is accepted.
// Throughput: one sample per cycle unless m_ready holds a result or a deque is draining;
// every deque update is local to a cell and its neighbors. After the window is made
// smaller, the first sample waits while each deque shifts out its extra stale heads.
// Reset (aresetn low at a clock edge) empties both cell rows, clears the sample count
// and the result valid flag, and sets window_size to 1.
module sliding_window_min_max import swmm_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [DATA_W-1:0]      m_window_min,
    output logic signed [DATA_W-1:0]      m_window_max,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    localparam entry_t EMPTY = '0;

    logic [CFG_W-1:0]         win_reg;
    logic [CFG_W-1:0]         win_next;
    logic [SEEN_W-1:0]        seen_reg;
    logic [SEEN_W-1:0]        seen_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [DATA_W-1:0] min_reg;
    logic signed [DATA_W-1:0] min_next;
    logic signed [DATA_W-1:0] max_reg;
    logic signed [DATA_W-1:0] max_next;

    logic [AGE_W-1:0] eff_win;
    logic             step;
    logic             max_head_old;
    logic             min_head_old;
    logic             max_drain;
    logic             min_drain;
    logic             drain;
    ctrl_t            max_ctrl;
    ctrl_t            min_ctrl;

    entry_t           max_entries [MAX_WINDOW+1];
    entry_t           min_entries [MAX_WINDOW+1];
    entry_t           max_nexts   [MAX_WINDOW];
    entry_t           min_nexts   [MAX_WINDOW];
    logic [MAX_WINDOW:0] max_keep;
    logic [MAX_WINDOW:0] min_keep;

    assign max_entries[MAX_WINDOW] = EMPTY;
    assign min_entries[MAX_WINDOW] = EMPTY;
    assign max_keep[0] = 1'b1;
    assign min_keep[0] = 1'b1;

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cells
        swmm_cell u_max_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (max_ctrl),
            .right_entry (max_entries[i+1]),
            .left_keep   (max_keep[i]),
            .entry       (max_entries[i]),
            .entry_next  (max_nexts[i]),
            .keep        (max_keep[i+1])
        );
        swmm_cell u_min_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (min_ctrl),
            .right_entry (min_entries[i+1]),
            .left_keep   (min_keep[i]),
            .entry       (min_entries[i]),
            .entry_next  (min_nexts[i]),
            .keep        (min_keep[i+1])
        );
    end

    always_comb begin
        if (win_reg == '0) begin
            eff_win = AGE_W'(1);
        end else if (32'(win_reg) > 32'(MAX_WINDOW)) begin
            eff_win = AGE_W'(MAX_WINDOW);
        end else begin
            eff_win = AGE_W'(win_reg);
        end

        max_head_old = max_entries[0].valid && (max_entries[0].age >= eff_win);
        min_head_old = min_entries[0].valid && (min_entries[0].age >= eff_win);
        max_drain    = max_entries[1].valid && (max_entries[1].age >= eff_win);
        min_drain    = min_entries[1].valid && (min_entries[1].age >= eff_win);
        drain        = s_valid && !s_restart && (max_drain || min_drain);

        s_ready = !drain && (!m_valid_reg || m_ready);
        step    = s_valid && s_ready;

        max_ctrl.step     = step;
        max_ctrl.shift    = step ? max_head_old : (drain && max_drain);
        max_ctrl.clear    = s_restart;
        max_ctrl.keep_max = 1'b1;
        max_ctrl.sample   = s_sample;

        min_ctrl.step     = step;
        min_ctrl.shift    = step ? min_head_old : (drain && min_drain);
        min_ctrl.clear    = s_restart;
        min_ctrl.keep_max = 1'b0;
        min_ctrl.sample   = s_sample;

        seen_next    = seen_reg;
        m_valid_next = m_valid_reg && !m_ready;
        min_next     = min_reg;
        max_next     = max_reg;
        if (step) begin
            if (s_restart) begin
                seen_next = SEEN_W'(1);
            end else if (seen_reg != SEEN_LIMIT) begin
                seen_next = seen_reg + SEEN_W'(1);
            end
            if (32'(seen_next) >= 32'(eff_win)) begin
                m_valid_next = 1'b1;
                min_next     = DATA_W'(min_nexts[0].value);
                max_next     = DATA_W'(max_nexts[0].value);
            end
        end

        win_next = win_reg;
        if (psel && penable && pwrite && pready) begin
            win_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= WIN_RESET;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            win_reg     <= win_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        min_reg <= min_next;
        max_reg <= max_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_window_min = min_reg;
    assign m_window_max = max_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr == WINDOW_SIZE_ADDR) ? DATA_W'(win_reg) : '0;

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_valid && s_ready))
        else $error("result appeared without an accepted request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($signed(max_reg) >= $signed(min_reg)))
        else $error("window maximum below window minimum");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (max_entries[0].valid && min_entries[0].valid)
            |-> ($signed(max_entries[0].value) >= $signed(min_entries[0].value)))
        else $error("deque heads out of order");

    assert property (@(posedge aclk) disable iff (!aresetn)
        max_entries[1].valid |-> (max_entries[0].valid
                                  && (max_entries[0].age > max_entries[1].age)))
        else $error("max deque ages not decreasing toward the tail");

endmodule

// ===== rtl/swmm_cell.sv =====
module swmm_cell import swmm_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  ctrl_t  ctrl,
    input  entry_t right_entry,
    input  logic   left_keep,
    output entry_t entry,
    output entry_t entry_next,
    output logic   keep
);

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic [AGE_W-1:0]              age_reg;
    logic [AGE_W-1:0]              age_next;
    entry_t                        own;
    entry_t                        src;
    logic                          greater;
    logic                          less;

    always_comb begin
        own.valid = valid_reg;
        own.value = value_reg;
        own.age   = age_reg;
        src       = ctrl.shift ? right_entry : own;
        greater   = $signed(src.value) > $signed(ctrl.sample);
        less      = $signed(src.value) < $signed(ctrl.sample);
        keep      = !ctrl.clear && src.valid && (ctrl.keep_max ? greater : less);

        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.step) begin
            // Entries still beating the new sample age by one; the first
            // losing entry takes the sample and everything behind it drops.
            if (keep) begin
                valid_next = 1'b1;
                value_next = src.value;
                age_next   = src.age + AGE_W'(1);
            end else if (left_keep) begin
                valid_next = 1'b1;
                value_next = ctrl.sample;
                age_next   = AGE_W'(1);
            end else begin
                valid_next = 1'b0;
                value_next = src.value;
                age_next   = src.age;
            end
        end else if (ctrl.shift) begin
            valid_next = src.valid;
            value_next = src.value;
            age_next   = src.age;
        end

        entry            = own;
        entry_next.valid = valid_next;
        entry_next.value = value_next;
        entry_next.age   = age_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

endmodule
